@@ rtl/core/keyed_siphash128_engine_top_defines.svh @@
// assertion macros for the keyed siphash engine checker
`ifndef KEYED_SIPHASH128_ENGINE_TOP_DEFINES_SVH
`define KEYED_SIPHASH128_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define KSH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("ksh check failed");

// next-cycle implication
`define KSH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("ksh check failed");

`endif

@@ rtl/core/ksh_pkg.sv @@
`timescale 1ns / 1ps
package ksh_pkg;

	localparam logic [1:0] MODE_KEY = 2'd0;
	localparam logic [1:0] MODE_MSG = 2'd1;
	localparam logic [1:0] MODE_FIN = 2'd2;

	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
	localparam logic [31:0] LANE_START0 = 32'h736f_6d65;
	localparam logic [31:0] LANE_START1 = 32'h646f_7261;
	localparam logic [31:0] LANE_START2 = 32'h6c79_6765;
	localparam logic [31:0] LANE_START3 = 32'h7465_6462;

	localparam logic [63:0] SIP_INIT0 = 64'h736f_6d65_7073_6575;
	localparam logic [63:0] SIP_INIT1 = 64'h646f_7261_6e64_6f6d;
	localparam logic [63:0] SIP_INIT2 = 64'h6c79_6765_6e65_7261;
	localparam logic [63:0] SIP_INIT3 = 64'h7465_6462_7974_6573;
	localparam logic [63:0] TAG_EE = 64'h0000_0000_0000_00ee;
	localparam logic [63:0] TAG_DD = 64'h0000_0000_0000_00dd;

	localparam logic [2:0] WORD_POS_LAST = 3'd7;
	localparam logic [2:0] COMP_HALF_LAST = 3'd3;
	localparam logic [2:0] FIN_HALF_LAST = 3'd7;

	typedef struct packed {
		logic [63:0] v0;
		logic [63:0] v1;
		logic [63:0] v2;
		logic [63:0] v3;
	} sip_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIN,
		ST_COMP,
		ST_MXOR,
		ST_FIN1,
		ST_H0,
		ST_FIN2,
		ST_OUT
	} ksh_state_t;

	typedef struct packed {
		logic idle;
		logic min;
		logic half;
		logic half_b;
		logic mxor;
		logic ee;
		logic h0_cap;
		logic emit;
	} ksh_ctl_t;

endpackage

@@ rtl/core/ksh_half_round.sv @@
`timescale 1ns / 1ps
module ksh_half_round
	import ksh_pkg::*;
(
	input  sip_state_t v,
	input  logic       second,
	output sip_state_t q
);

	logic [63:0] sum_a;
	logic [63:0] sum_c;

	always_comb begin
		if (!second) begin
			sum_a = v.v0 + v.v1;
			sum_c = v.v2 + v.v3;
			q.v0 = {sum_a[31:0], sum_a[63:32]};
			q.v1 = {v.v1[50:0], v.v1[63:51]} ^ sum_a;
			q.v2 = sum_c;
			q.v3 = {v.v3[47:0], v.v3[63:48]} ^ sum_c;
		end else begin
			sum_a = v.v0 + v.v3;
			sum_c = v.v2 + v.v1;
			q.v0 = sum_a;
			q.v1 = {v.v1[46:0], v.v1[63:47]} ^ sum_c;
			q.v2 = {sum_c[31:0], sum_c[63:32]};
			q.v3 = {v.v3[42:0], v.v3[63:43]} ^ sum_a;
		end
	end

endmodule

@@ rtl/core/ksh_key_fold.sv @@
`timescale 1ns / 1ps
module ksh_key_fold
	import ksh_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fold,
	input  logic        clear,
	input  logic [7:0]  data_byte,
	output logic [63:0] k0,
	output logic [63:0] k1
);

	logic [31:0] lane_q [4];
	logic [1:0]  ptr_q;
	logic [31:0] prod;

	assign prod = (lane_q[ptr_q] ^ {24'b0, data_byte}) * FNV_PRIME;
	assign k0 = {lane_q[0], lane_q[1]};
	assign k1 = {lane_q[2], lane_q[3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q[0] <= LANE_START0;
			lane_q[1] <= LANE_START1;
			lane_q[2] <= LANE_START2;
			lane_q[3] <= LANE_START3;
			ptr_q <= '0;
		end else if (clear) begin
			lane_q[0] <= LANE_START0;
			lane_q[1] <= LANE_START1;
			lane_q[2] <= LANE_START2;
			lane_q[3] <= LANE_START3;
			ptr_q <= '0;
		end else if (fold) begin
			lane_q[ptr_q] <= prod;
			ptr_q <= ptr_q + 2'd1;
		end
	end

endmodule

@@ rtl/core/ksh_ctrl.sv @@
`timescale 1ns / 1ps
module ksh_ctrl
	import ksh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     go,
	input  logic     go_fin,
	input  logic     out_free,
	output ksh_ctl_t ctl
);

	ksh_state_t state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       fin_q, fin_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			fin_q <= fin_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		fin_d = fin_q;
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.idle = 1'b1;
				cnt_d = '0;
				if (go) begin
					state_d = ST_MIN;
					fin_d = go_fin;
				end
			end
			ST_MIN: begin
				ctl.min = 1'b1;
				state_d = ST_COMP;
			end
			ST_COMP: begin
				ctl.half = 1'b1;
				ctl.half_b = cnt_q[0];
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == COMP_HALF_LAST) begin
					cnt_d = '0;
					state_d = ST_MXOR;
				end
			end
			ST_MXOR: begin
				ctl.mxor = 1'b1;
				ctl.ee = fin_q;
				state_d = fin_q ? ST_FIN1 : ST_IDLE;
			end
			ST_FIN1: begin
				ctl.half = 1'b1;
				ctl.half_b = cnt_q[0];
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == FIN_HALF_LAST) begin
					state_d = ST_H0;
				end
			end
			ST_H0: begin
				ctl.h0_cap = 1'b1;
				cnt_d = '0;
				state_d = ST_FIN2;
			end
			ST_FIN2: begin
				ctl.half = 1'b1;
				ctl.half_b = cnt_q[0];
				cnt_d = cnt_q + 3'd1;
				if (cnt_q == FIN_HALF_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					ctl.emit = 1'b1;
					fin_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/core/keyed_siphash128_engine_top.sv @@
`timescale 1ns / 1ps
// key bytes, unused codes and non-word-completing message bytes: taken while the engine stays idle
// word-completing message byte: word xor, four half-rounds, word xor, then idle again
// finish: word steps, tag xor, eight half-rounds, tag xor, eight half-rounds, digest beat
// one shared half-round unit, one half-round per cycle; digest waits on a held output beat
// async reset clears control, key lanes return to their start constants, no hash in flight
module keyed_siphash128_engine_top
	import ksh_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,  // data_byte
	input  logic [1:0]   s_tuser,  // mode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata   // digest_head, digest_tail
);

	ksh_ctl_t    ctl;
	sip_state_t  v_q, v_half;
	logic [63:0] k0, k1;
	logic [63:0] pending_q, pending_new, m_q;
	logic [7:0]  len_q;
	logic        started_q;
	logic [63:0] h0_q, h_sum;
	logic        m_tvalid_q;
	logic [127:0] m_tdata_q;
	logic        accept, fold, load, is_msg, is_fin, go, out_free;

	assign accept = s_tvalid & ctl.idle;
	assign s_tready = ctl.idle;
	assign is_msg = accept & (s_tuser == MODE_MSG);
	assign is_fin = accept & (s_tuser == MODE_FIN);
	assign fold = accept & (s_tuser == MODE_KEY) & ~started_q;
	assign load = (is_msg | is_fin) & ~started_q;
	assign go = is_fin | (is_msg & (len_q[2:0] == WORD_POS_LAST));
	assign out_free = ~m_tvalid_q | m_tready;
	assign pending_new = pending_q | ({56'b0, s_tdata} << {len_q[2:0], 3'b000});
	assign h_sum = v_q.v0 ^ v_q.v1 ^ v_q.v2 ^ v_q.v3;

	ksh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.go_fin   (is_fin),
		.out_free (out_free),
		.ctl      (ctl)
	);

	ksh_key_fold u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.fold      (fold),
		.clear     (ctl.emit),
		.data_byte (s_tdata),
		.k0        (k0),
		.k1        (k1)
	);

	ksh_half_round u_round (
		.v      (v_q),
		.second (ctl.half_b),
		.q      (v_half)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			pending_q <= '0;
			len_q <= '0;
		end else if (ctl.emit) begin
			started_q <= 1'b0;
			pending_q <= '0;
			len_q <= '0;
		end else begin
			if (load) begin
				started_q <= 1'b1;
			end
			if (is_msg) begin
				len_q <= len_q + 8'd1;
				pending_q <= (len_q[2:0] == WORD_POS_LAST) ? '0 : pending_new;
			end
		end
	end

	// sip words and the word being absorbed
	always_ff @(posedge clk) begin
		if (is_msg) begin
			m_q <= pending_new;
		end else if (is_fin) begin
			m_q <= pending_q | {len_q, 56'b0};
		end
		if (load) begin
			v_q.v0 <= k0 ^ SIP_INIT0;
			v_q.v1 <= k1 ^ SIP_INIT1 ^ TAG_EE;
			v_q.v2 <= k0 ^ SIP_INIT2;
			v_q.v3 <= k1 ^ SIP_INIT3;
		end else if (ctl.min) begin
			v_q.v3 <= v_q.v3 ^ m_q;
		end else if (ctl.half) begin
			v_q <= v_half;
		end else if (ctl.mxor) begin
			v_q.v0 <= v_q.v0 ^ m_q;
			if (ctl.ee) begin
				v_q.v2 <= v_q.v2 ^ TAG_EE;
			end
		end else if (ctl.h0_cap) begin
			v_q.v1 <= v_q.v1 ^ TAG_DD;
		end
		if (ctl.h0_cap) begin
			h0_q <= h_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			m_tdata_q <= {h_sum[31:0], h_sum[63:32], h0_q[31:0], h0_q[63:32]};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

@@ rtl/core/ksh_checker.sv @@
`timescale 1ns / 1ps
`include "keyed_siphash128_engine_top_defines.svh"
module ksh_checker
	import ksh_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [7:0]   s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata
);

	// held output beat keeps its data
	`KSH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// finish always occupies the engine
	`KSH_ASSERT_NEXT(a_fin_busy, clk, arst_n, s_tvalid && s_tready && s_tuser == MODE_FIN, !s_tready)
	// key bytes never stall the input
	`KSH_ASSERT_NEXT(a_key_free, clk, arst_n, s_tvalid && s_tready && s_tuser == MODE_KEY, s_tready)
	// digest beat only appears at the end of a busy stretch
	`KSH_ASSERT_NOW(a_out_after_busy, clk, arst_n, $rose(m_tvalid), !$past(s_tready))

endmodule

bind keyed_siphash128_engine_top ksh_checker u_ksh_checker (.*);
